@@ rtl/asf_pkg.sv @@
// Shared types, constants and constant tables for the accelerometer sample
// filter and scaler. No dependencies; used by asf_core, top and asf_check.
package asf_pkg;

  // Default moving-average depth
  localparam int ASF_FILTER_DEPTH = 4;

  // Field widths
  localparam int ASF_SAMPLE_W = 14;
  localparam int ASF_SUM_W    = 16;
  localparam int ASF_ACCEL_W  = 18;
  localparam int ASF_IN_W     = 48;
  localparam int ASF_OUT_W    = 96;

  // Reciprocal shifts: exact floor division for every operand in range
  localparam int ASF_DIV_SHIFT = 28;
  localparam int ASF_RND_SHIFT = 46;

  localparam logic [2:0] ASF_RANGE_RESET = 3'd2;

  // Axis codes (frame order)
  localparam logic [1:0] ASF_AXIS_X = 2'd0;
  localparam logic [1:0] ASF_AXIS_Y = 2'd1;
  localparam logic [1:0] ASF_AXIS_Z = 2'd2;

  // Range codes
  localparam logic [2:0] ASF_RANGE_1G0  = 3'd0;
  localparam logic [2:0] ASF_RANGE_1G5  = 3'd1;
  localparam logic [2:0] ASF_RANGE_2G   = 3'd2;
  localparam logic [2:0] ASF_RANGE_3G   = 3'd3;
  localparam logic [2:0] ASF_RANGE_4G   = 3'd4;
  localparam logic [2:0] ASF_RANGE_8G   = 3'd5;
  localparam logic [2:0] ASF_RANGE_16G  = 3'd6;

  // Gain in units of 1e-4, per axis
  localparam logic [14:0] ASF_GAIN_X = 15'd10365;
  localparam logic [14:0] ASF_GAIN_Y = 15'd10300;
  localparam logic [14:0] ASF_GAIN_Z = 15'd10285;

  // ceil(2^46 / (2 * gain)): rounding divide by a multiply
  localparam logic [31:0] ASF_RECIP_X =
    32'(((64'd1 << ASF_RND_SHIFT) + 64'd20729) / 64'd20730);
  localparam logic [31:0] ASF_RECIP_Y =
    32'(((64'd1 << ASF_RND_SHIFT) + 64'd20599) / 64'd20600);
  localparam logic [31:0] ASF_RECIP_Z =
    32'(((64'd1 << ASF_RND_SHIFT) + 64'd20569) / 64'd20570);

  // Control from the stream front end to the core
  typedef struct packed {
    logic start;
    logic commit_ok;
  } asf_ctl_t;

  // Status from the core
  typedef struct packed {
    logic idle;
    logic done;
  } asf_status_t;

  // One result; packed so that accel_x sits in the lowest bits
  typedef struct packed {
    logic [ASF_SAMPLE_W-1:0] filtered_z;
    logic [ASF_SAMPLE_W-1:0] filtered_y;
    logic [ASF_SAMPLE_W-1:0] filtered_x;
    logic [ASF_ACCEL_W-1:0]  accel_z;
    logic [ASF_ACCEL_W-1:0]  accel_y;
    logic [ASF_ACCEL_W-1:0]  accel_x;
  } asf_result_t;

  // 5 * twice the full-scale range; the unused code acts as 1 g
  function automatic logic [7:0] asf_k5s2(input logic [2:0] code);
    logic [7:0] k;
    unique case (code)
      ASF_RANGE_1G0: k = 8'd10;
      ASF_RANGE_1G5: k = 8'd15;
      ASF_RANGE_2G:  k = 8'd20;
      ASF_RANGE_3G:  k = 8'd30;
      ASF_RANGE_4G:  k = 8'd40;
      ASF_RANGE_8G:  k = 8'd80;
      ASF_RANGE_16G: k = 8'd160;
      default:       k = 8'd10;
    endcase
    return k;
  endfunction

  // Eight times the offset in units of 1e-4
  function automatic logic signed [22:0] asf_off8(input logic [1:0] axis);
    logic signed [22:0] o;
    unique case (axis)
      ASF_AXIS_X: o = 23'sd2760;
      ASF_AXIS_Y: o = -23'sd800;
      ASF_AXIS_Z: o = 23'sd1480;
      default:    o = '0;
    endcase
    return o;
  endfunction

  function automatic logic [14:0] asf_gain(input logic [1:0] axis);
    logic [14:0] g;
    unique case (axis)
      ASF_AXIS_X: g = ASF_GAIN_X;
      ASF_AXIS_Y: g = ASF_GAIN_Y;
      ASF_AXIS_Z: g = ASF_GAIN_Z;
      default:    g = ASF_GAIN_X;
    endcase
    return g;
  endfunction

  function automatic logic [31:0] asf_recip_g(input logic [1:0] axis);
    logic [31:0] r;
    unique case (axis)
      ASF_AXIS_X: r = ASF_RECIP_X;
      ASF_AXIS_Y: r = ASF_RECIP_Y;
      ASF_AXIS_Z: r = ASF_RECIP_Z;
      default:    r = ASF_RECIP_X;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/asf_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module asf_ram #(
  parameter int WIDTH = 42,
  parameter int DEPTH = 4
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/asf_mul.sv @@
// Shared unsigned 31 x 32 multiplier with a registered product.
// No dependencies; used by asf_core for division, scaling and rounding.
module asf_mul (
  input  logic        clk,
  input  logic        en,
  input  logic [30:0] a,
  input  logic [31:0] b,
  output logic [62:0] p
);

  // Register the product
  always_ff @(posedge clk) begin
    if (en) begin
      p <= 63'(a) * 63'(b);
    end
  end

endmodule

@@ rtl/asf_core.sv @@
// Filter and scaling sequencer: tap ring in asf_ram, one shared asf_mul.
// Depends on asf_pkg, asf_ram and asf_mul.
module asf_core #(
  parameter int FILTER_DEPTH = asf_pkg::ASF_FILTER_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  asf_pkg::asf_ctl_t                 ctl,
  input  logic [asf_pkg::ASF_IN_W-1:0]      in_bytes,
  input  logic [2:0]                        range_code,
  output asf_pkg::asf_status_t              status,
  output asf_pkg::asf_result_t              result
);
  import asf_pkg::*;

  localparam int SLOT_W = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
  localparam int ROW_W  = 3 * ASF_SAMPLE_W;
  localparam logic [31:0] RECIP_D =
    32'(((64'd1 << ASF_DIV_SHIFT) + 64'(FILTER_DEPTH) - 64'd1) / 64'(FILTER_DEPTH));
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(FILTER_DEPTH - 1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_LOAD = 8'b0000_0010,
    S_DIV  = 8'b0000_0100,
    S_ACC  = 8'b0000_1000,
    S_NMUL = 8'b0001_0000,
    S_QMUL = 8'b0010_0000,
    S_RND  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } asf_state_t;

  asf_state_t state;
  logic [1:0] axis;
  logic [SLOT_W-1:0] slot;
  logic [FILTER_DEPTH-1:0] row_valid;
  logic signed [ASF_SUM_W-1:0] sums [3];

  logic [ASF_SAMPLE_W-1:0] samp [3];
  logic [ROW_W-1:0] old_row;
  logic [ROW_W-1:0] new_row;
  logic neg_n;
  logic [ASF_ACCEL_W-1:0] acc_res [3];

  logic [ROW_W-1:0] ram_rdata;
  logic ram_we;
  logic ram_re;

  logic mul_en;
  logic [30:0] mul_a;
  logic [31:0] mul_b;
  logic [62:0] mul_p;

  logic [ASF_SAMPLE_W-1:0] cur_samp;
  logic signed [ASF_SUM_W-1:0] cur_sum;
  logic [ASF_SAMPLE_W-1:0] samp_mag;
  logic [ASF_SAMPLE_W-1:0] sum_mag;
  logic [14:0] div_q;
  logic [ASF_SAMPLE_W-1:0] tap;
  logic [ASF_SAMPLE_W-1:0] old_tap;
  logic signed [ASF_SUM_W-1:0] sum_next;
  logic [20:0] scaled;
  logic signed [22:0] n_val;
  logic [20:0] n_mag;
  logic [30:0] rnd_a;
  logic [16:0] q;
  logic [ASF_ACCEL_W-1:0] res;

  // Tap ring: one row of three taps per slot
  asf_ram #(
    .WIDTH(ROW_W),
    .DEPTH(FILTER_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(slot),
    .wdata(new_row),
    .re   (ram_re),
    .raddr(slot),
    .rdata(ram_rdata)
  );

  asf_mul u_mul (
    .clk(clk),
    .en (mul_en),
    .a  (mul_a),
    .b  (mul_b),
    .p  (mul_p)
  );

  assign ram_re = (state == S_IDLE) && ctl.start;
  assign ram_we = (state == S_DONE) && ctl.commit_ok;

  // Per-axis datapath
  always_comb begin
    cur_samp = samp[axis];
    cur_sum  = sums[axis];
    samp_mag = cur_samp[ASF_SAMPLE_W-1] ? ASF_SAMPLE_W'(-cur_samp) : cur_samp;
    sum_mag  = cur_sum[ASF_SUM_W-1] ? ASF_SAMPLE_W'(-cur_sum) : ASF_SAMPLE_W'(cur_sum);
    // Truncate toward zero: divide the magnitude, then restore the sign
    div_q    = mul_p[ASF_DIV_SHIFT +: 15];
    tap      = cur_samp[ASF_SAMPLE_W-1] ? ASF_SAMPLE_W'(-div_q) : ASF_SAMPLE_W'(div_q);
    old_tap  = old_row[axis*ASF_SAMPLE_W +: ASF_SAMPLE_W];
    sum_next = cur_sum - ASF_SUM_W'(signed'(old_tap)) + ASF_SUM_W'(signed'(tap));
    // Numerator 5 * sum * S2 + 8 * offset
    scaled   = mul_p[20:0];
    n_val    = (cur_sum[ASF_SUM_W-1] ? -signed'({2'b00, scaled}) : signed'({2'b00, scaled}))
               + asf_off8(axis);
    n_mag    = 21'(n_val[22] ? -n_val : n_val);
    // Round half away from zero: (2 * 512 * |N| + G) / (2 * G)
    rnd_a    = {n_mag, 10'b0} + 31'(asf_gain(axis));
    q        = mul_p[ASF_RND_SHIFT +: 17];
    res      = neg_n ? ASF_ACCEL_W'(-{1'b0, q}) : {1'b0, q};
  end

  // Share the multiplier between the three products
  always_comb begin
    unique case (state)
      S_DIV: begin
        mul_a = 31'(samp_mag);
        mul_b = RECIP_D;
      end
      S_NMUL: begin
        mul_a = 31'(sum_mag);
        mul_b = 32'(asf_k5s2(range_code));
      end
      S_QMUL: begin
        mul_a = rnd_a;
        mul_b = asf_recip_g(axis);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_en = (state == S_DIV) || (state == S_NMUL) || (state == S_QMUL);

  // Sequencer and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      axis      <= ASF_AXIS_X;
      slot      <= '0;
      row_valid <= '0;
      sums      <= '{default: '0};
    end else begin
      unique case (state)
        S_IDLE: begin
          if (ctl.start) begin
            state <= S_LOAD;
            axis  <= ASF_AXIS_X;
          end
        end
        S_LOAD: state <= S_DIV;
        S_DIV:  state <= S_ACC;
        S_ACC: begin
          sums[axis] <= sum_next;
          state      <= S_NMUL;
        end
        S_NMUL: state <= S_QMUL;
        S_QMUL: state <= S_RND;
        S_RND: begin
          if (axis == ASF_AXIS_Z) begin
            state <= S_DONE;
          end else begin
            axis  <= axis + 2'd1;
            state <= S_DIV;
          end
        end
        S_DONE: begin
          if (ctl.commit_ok) begin
            row_valid[slot] <= 1'b1;
            slot  <= (slot == SLOT_LAST) ? '0 : slot + 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && ctl.start) begin
      // Swap chip X and Y, drop the two status bits
      samp[0] <= {in_bytes[31:24], in_bytes[23:18]};
      samp[1] <= {in_bytes[15:8],  in_bytes[7:2]};
      samp[2] <= {in_bytes[47:40], in_bytes[39:34]};
    end
    if (state == S_LOAD) begin
      old_row <= row_valid[slot] ? ram_rdata : '0;
    end
    if (state == S_ACC) begin
      new_row[axis*ASF_SAMPLE_W +: ASF_SAMPLE_W] <= tap;
    end
    if (state == S_QMUL) begin
      neg_n <= n_val[22];
    end
    if (state == S_RND) begin
      acc_res[axis] <= res;
    end
  end

  assign status.idle = (state == S_IDLE);
  assign status.done = (state == S_DONE) && ctl.commit_ok;

  assign result.accel_x    = acc_res[0];
  assign result.accel_y    = acc_res[1];
  assign result.accel_z    = acc_res[2];
  assign result.filtered_x = sums[0][ASF_SAMPLE_W-1:0];
  assign result.filtered_y = sums[1][ASF_SAMPLE_W-1:0];
  assign result.filtered_z = sums[2][ASF_SAMPLE_W-1:0];

endmodule

@@ rtl/accel_sample_filter_scale.sv @@
// Top level of the accelerometer sample filter and scaler: stream ports,
// range register and output register. Depends on asf_pkg and asf_core.
//
//  channel  | direction | request moves
//  ---------+-----------+-------------------------------------------
//  s_axis   | in        | six chip data bytes of one frame
//  m_axis   | out       | calibrated Q5.12 g and filtered counts
//  cfg      | in        | full-scale range code, written directly
//
// After a request is accepted the core does one ring read, five steps per axis
// through the shared multiplier and one write-back that also loads the output
// register, then returns to idle; the next request is accepted only in idle.
// Reset clears the taps by valid bits, so the block is ready at once. A stalled
// output holds the result; the core waits before write-back while the output
// register is occupied and not being taken.
module accel_sample_filter_scale #(
  parameter int FILTER_DEPTH = asf_pkg::ASF_FILTER_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [2:0]                     cfg_wdata,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // x_low_byte, x_high_byte, y_low_byte, y_high_byte, z_low_byte, z_high_byte
  input  logic [asf_pkg::ASF_IN_W-1:0]   s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // accel_x, accel_y, accel_z, filtered_x, filtered_y, filtered_z
  output logic [asf_pkg::ASF_OUT_W-1:0]  m_axis_tdata
);
  import asf_pkg::*;

  logic [2:0] range_code;
  asf_ctl_t ctl;
  asf_status_t status;
  asf_result_t result;
  asf_result_t out_data;
  logic out_valid;

  asf_core #(
    .FILTER_DEPTH(FILTER_DEPTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .in_bytes  (s_axis_tdata),
    .range_code(range_code),
    .status    (status),
    .result    (result)
  );

  assign ctl.start     = s_axis_tvalid && status.idle;
  assign ctl.commit_ok = !out_valid || m_axis_tready;
  assign s_axis_tready = status.idle;

  // Range register
  always_ff @(posedge clk) begin
    if (rst) begin
      range_code <= ASF_RANGE_RESET;
    end else if (cfg_we) begin
      range_code <= cfg_wdata;
    end
  end

  // Output register: load on commit, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (status.done) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (status.done) begin
      out_data <= result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule

@@ rtl/asf_check.sv @@
// Port-level assertions for accel_sample_filter_scale, bound to the top.
// Depends on asf_pkg for the data width.
module asf_check (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [asf_pkg::ASF_OUT_W-1:0] m_axis_tdata
);
  import asf_pkg::*;

  // Come out of reset idle and empty
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!m_axis_tvalid && s_axis_tready))
    else $error("not idle after reset");

  // Work on one request at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while busy");

  // A fresh result only follows a finished request
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared with no request in progress");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind accel_sample_filter_scale asf_check u_asf_check (.*);
